### src/pcx_pkg.sv
// ----------------------------------------------------------------------------
// pcx_pkg: shared constants and types of the PCX run-length decoder
// Frame geometry, header field offsets, result codes and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pcx_pkg;

    localparam int FRAME_WIDTH  = 320;
    localparam int FRAME_HEIGHT = 200;
    localparam int HEADER_BYTES = 128;

    localparam int OFF_W  = $clog2(HEADER_BYTES);
    localparam int COL_W  = $clog2(FRAME_WIDTH + 2);
    localparam int ROW_W  = $clog2(FRAME_HEIGHT);
    localparam int ADDR_W = 16;
    localparam int RUN_W  = 6;
    localparam int SIZE_W = 16;

    localparam logic [7:0] MANUFACTURER = 8'h0a;
    localparam logic [7:0] VERSION      = 8'd5;
    localparam logic [7:0] ENCODING     = 8'd1;
    localparam logic [7:0] BITS_PER_PIX = 8'd8;
    localparam logic [7:0] RUN_MARK     = 8'hC0;
    localparam logic [7:0] RUN_MASK     = 8'h3F;

    localparam logic [OFF_W-1:0] OFF_MANUF   = OFF_W'(0);
    localparam logic [OFF_W-1:0] OFF_VERSION = OFF_W'(1);
    localparam logic [OFF_W-1:0] OFF_ENCODE  = OFF_W'(2);
    localparam logic [OFF_W-1:0] OFF_BPP     = OFF_W'(3);
    localparam logic [OFF_W-1:0] OFF_XMAX_LO = OFF_W'(8);
    localparam logic [OFF_W-1:0] OFF_XMAX_HI = OFF_W'(9);
    localparam logic [OFF_W-1:0] OFF_YMAX_LO = OFF_W'(10);
    localparam logic [OFF_W-1:0] OFF_YMAX_HI = OFF_W'(11);
    localparam logic [OFF_W-1:0] OFF_LAST    = OFF_W'(HEADER_BYTES - 1);

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_HDR = 2'd1;
    localparam logic [1:0] ST_MAL = 2'd2;

    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic       capture;
        logic       hdr_step;
        logic       set_pending;
        logic       len_pending;
        logic       load_run;
        logic       emit_pixel;
        logic       emit_status;
        logic       run_last;
        logic [1:0] status_code;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic last;
        logic hdr_last;
        logic hdr_bad;
        logic rows_zero;
        logic run_byte;
        logic run_overflow;
        logic run_zero;
        logic cnt_one;
        logic frame_done;
    } t_sts;

endpackage

### src/pcx_dp.sv
// ----------------------------------------------------------------------------
// pcx_dp: datapath of the PCX run-length decoder
// Holds the captured byte, header fields, frame position, run counter and
// the output register.
// ----------------------------------------------------------------------------
module pcx_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_last_byte,
    input  pcx_pkg::t_cmd               i_cmd,
    output pcx_pkg::t_sts               o_sts,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic                        o_item_kind,
    output logic [pcx_pkg::ADDR_W-1:0]  o_pixel_addr,
    output logic [7:0]                  o_pixel_value,
    output logic [1:0]                  o_status_code,
    output logic                        o_run_last
);

    logic [7:0]                  r_byte;
    logic                        r_last;
    logic [pcx_pkg::OFF_W-1:0]   r_hdr_off;
    logic                        r_hdr_ok;
    logic [pcx_pkg::SIZE_W-1:0]  r_max_col;
    logic [pcx_pkg::SIZE_W-1:0]  r_row_cnt;
    logic [pcx_pkg::RUN_W-1:0]   r_pending;
    logic [pcx_pkg::RUN_W-1:0]   r_cnt;
    logic [pcx_pkg::COL_W-1:0]   r_col;
    logic [pcx_pkg::ROW_W-1:0]   r_row;
    logic [pcx_pkg::ADDR_W-1:0]  r_row_base;

    logic                        r_out_valid;
    logic                        r_kind;
    logic [pcx_pkg::ADDR_W-1:0]  r_addr;
    logic [7:0]                  r_value;
    logic [1:0]                  r_status;
    logic                        r_run_last;

    logic [pcx_pkg::RUN_W-1:0]   len;
    logic [pcx_pkg::COL_W:0]     col_next;
    logic [pcx_pkg::ROW_W:0]     row_next;
    logic                        wrap;
    logic                        out_free;

    assign len      = i_cmd.len_pending ? r_pending : pcx_pkg::RUN_W'(1);
    assign col_next = {1'b0, r_col} + 1'b1;
    assign row_next = {1'b0, r_row} + 1'b1;
    assign wrap     = pcx_pkg::SIZE_W'(col_next) > r_max_col;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_sts.out_free     = out_free;
        o_sts.last         = r_last;
        o_sts.hdr_last     = r_hdr_off == pcx_pkg::OFF_LAST;
        o_sts.hdr_bad      = !r_hdr_ok
                           || r_max_col >= pcx_pkg::SIZE_W'(pcx_pkg::FRAME_WIDTH)
                           || r_row_cnt >= pcx_pkg::SIZE_W'(pcx_pkg::FRAME_HEIGHT);
        o_sts.rows_zero    = r_row_cnt == '0;
        o_sts.run_byte     = (r_byte & pcx_pkg::RUN_MARK) == pcx_pkg::RUN_MARK;
        o_sts.run_overflow = (17'(len) + 17'(r_col)) > (17'(r_max_col) + 17'd2);
        o_sts.run_zero     = len == '0;
        o_sts.cnt_one      = r_cnt == pcx_pkg::RUN_W'(1);
        o_sts.frame_done   = wrap && (pcx_pkg::SIZE_W'(row_next) >= r_row_cnt);
    end

    // input capture and header fields
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_off <= '0;
            r_hdr_ok  <= 1'b1;
            r_max_col <= '0;
            r_row_cnt <= '0;
            r_pending <= '0;
        end else begin
            if (i_cmd.hdr_step) begin
                unique case (r_hdr_off)
                    pcx_pkg::OFF_MANUF:
                        if (r_byte != pcx_pkg::MANUFACTURER) r_hdr_ok <= 1'b0;
                    pcx_pkg::OFF_VERSION:
                        if (r_byte != pcx_pkg::VERSION) r_hdr_ok <= 1'b0;
                    pcx_pkg::OFF_ENCODE:
                        if (r_byte != pcx_pkg::ENCODING) r_hdr_ok <= 1'b0;
                    pcx_pkg::OFF_BPP:
                        if (r_byte != pcx_pkg::BITS_PER_PIX) r_hdr_ok <= 1'b0;
                    pcx_pkg::OFF_XMAX_LO: r_max_col[7:0]  <= r_byte;
                    pcx_pkg::OFF_XMAX_HI: r_max_col[15:8] <= r_byte;
                    pcx_pkg::OFF_YMAX_LO: r_row_cnt[7:0]  <= r_byte;
                    pcx_pkg::OFF_YMAX_HI: r_row_cnt[15:8] <= r_byte;
                    default: ;
                endcase
                if (r_hdr_off != pcx_pkg::OFF_LAST) begin
                    r_hdr_off <= r_hdr_off + 1'b1;
                end
            end
            if (i_cmd.set_pending) begin
                r_pending <= pcx_pkg::RUN_W'(r_byte & pcx_pkg::RUN_MASK);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_byte <= i_data_byte;
            r_last <= i_last_byte;
        end
    end

    // frame position and run counter; a run stays on its row and wraps
    // only after its last pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_row_base <= '0;
        end else begin
            if (i_cmd.load_run) begin
                r_cnt <= len;
            end else if (i_cmd.emit_pixel) begin
                r_cnt <= r_cnt - 1'b1;
                if (wrap && r_cnt == pcx_pkg::RUN_W'(1)) begin
                    r_col      <= '0;
                    r_row      <= r_row + 1'b1;
                    r_row_base <= r_row_base + pcx_pkg::ADDR_W'(pcx_pkg::FRAME_WIDTH);
                end else begin
                    r_col <= col_next[pcx_pkg::COL_W-1:0];
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_pixel || i_cmd.emit_status) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_pixel) begin
            r_kind     <= pcx_pkg::KIND_PIXEL;
            r_addr     <= r_row_base + pcx_pkg::ADDR_W'(r_col);
            r_value    <= r_byte;
            r_status   <= pcx_pkg::ST_OK;
            r_run_last <= i_cmd.run_last;
        end else if (i_cmd.emit_status) begin
            r_kind     <= pcx_pkg::KIND_STATUS;
            r_addr     <= '0;
            r_value    <= '0;
            r_status   <= i_cmd.status_code;
            r_run_last <= 1'b1;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_item_kind   = r_kind;
    assign o_pixel_addr  = r_addr;
    assign o_pixel_value = r_value;
    assign o_status_code = r_status;
    assign o_run_last    = r_run_last;

endmodule

### src/pcx_ctrl.sv
// ----------------------------------------------------------------------------
// pcx_ctrl: controller of the PCX run-length decoder
// Sequences header checks, run decoding, pixel emission and the final status.
// ----------------------------------------------------------------------------
module pcx_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  pcx_pkg::t_sts i_sts,
    output pcx_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IN   = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_RUN  = 3'd2;
    localparam logic [2:0] S_STAT = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_DATA   = 2'd1;
    localparam logic [1:0] PH_VALUE  = 2'd2;

    logic [2:0] r_state, n_state;
    logic [1:0] r_phase, n_phase;
    logic [1:0] r_code,  n_code;
    logic       stall;

    assign stall      = !(r_state == S_IN || r_state == S_DONE);
    assign o_in_stall = stall;

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_code  = r_code;
        o_cmd   = '0;
        o_cmd.capture     = i_in_valid && !stall;
        o_cmd.len_pending = r_phase == PH_VALUE;
        o_cmd.status_code = r_code;
        unique case (r_state)
            S_IN: begin
                if (i_in_valid) n_state = S_EVAL;
            end
            S_EVAL: begin
                unique case (r_phase)
                    PH_HEADER: begin
                        o_cmd.hdr_step = 1'b1;
                        n_state = S_IN;
                        if (i_sts.hdr_last) begin
                            n_state = S_STAT;
                            if (i_sts.hdr_bad)        n_code = pcx_pkg::ST_HDR;
                            else if (i_sts.rows_zero) n_code = pcx_pkg::ST_OK;
                            else if (i_sts.last)      n_code = pcx_pkg::ST_MAL;
                            else begin
                                n_phase = PH_DATA;
                                n_state = S_IN;
                            end
                        end else if (i_sts.last) begin
                            n_code  = pcx_pkg::ST_HDR;
                            n_state = S_STAT;
                        end
                    end
                    PH_DATA, PH_VALUE: begin
                        if (r_phase == PH_DATA && i_sts.run_byte) begin
                            o_cmd.set_pending = 1'b1;
                            if (i_sts.last) begin
                                n_code  = pcx_pkg::ST_MAL;
                                n_state = S_STAT;
                            end else begin
                                n_phase = PH_VALUE;
                                n_state = S_IN;
                            end
                        end else if (i_sts.run_overflow) begin
                            n_code  = pcx_pkg::ST_MAL;
                            n_state = S_STAT;
                        end else if (i_sts.run_zero) begin
                            n_phase = PH_DATA;
                            if (i_sts.last) begin
                                n_code  = pcx_pkg::ST_MAL;
                                n_state = S_STAT;
                            end else begin
                                n_state = S_IN;
                            end
                        end else begin
                            o_cmd.load_run = 1'b1;
                            n_phase = PH_DATA;
                            n_state = S_RUN;
                        end
                    end
                    default: n_state = S_IN;
                endcase
            end
            S_RUN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_pixel = 1'b1;
                    o_cmd.run_last   = i_sts.cnt_one && !i_sts.frame_done && !i_sts.last;
                    if (i_sts.cnt_one) begin
                        if (i_sts.frame_done) begin
                            n_code  = pcx_pkg::ST_OK;
                            n_state = S_STAT;
                        end else if (i_sts.last) begin
                            n_code  = pcx_pkg::ST_MAL;
                            n_state = S_STAT;
                        end else begin
                            n_state = S_IN;
                        end
                    end
                end
            end
            S_STAT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_status = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: n_state = S_DONE;
            default: n_state = S_IN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
            r_phase <= PH_HEADER;
            r_code  <= pcx_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_code  <= n_code;
        end
    end

endmodule

### src/pcx_rle_image_decoder_unit.sv
// ----------------------------------------------------------------------------
// pcx_rle_image_decoder_unit: 8-bit PCX run-length image decoder
// Checks the 128-byte PCX header, then expands the run-length data into
// pixel writes for a 320x200 frame and closes with one status word.
// ----------------------------------------------------------------------------
// A file enters one byte per input word, header first. Header bytes, run
// marker bytes and the value of an empty run are captured, then decoded;
// a literal pixel byte is captured, decoded, then emitted. A run value byte
// emits up to 63 pixel words, one per cycle while the output is not stalled,
// and input stays stalled until the last of them. Pixel words carry address
// row*320+column; the final word has item kind 1 and a status code of 0
// (fine), 1 (header rejected) or 2 (data malformed). After the status word
// every further input word is taken and dropped until reset. The consumer
// clears the frame beforehand; run_last marks the last word that an input
// byte caused. One output register parts the two channels.
// ----------------------------------------------------------------------------
module pcx_rle_image_decoder_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel: file bytes
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_last_byte,
    // output channel: pixel writes and final status
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_item_kind,
    output logic [pcx_pkg::ADDR_W-1:0]  o_pixel_addr,
    output logic [7:0]                  o_pixel_value,
    output logic [1:0]                  o_status_code,
    output logic                        o_run_last
);

    pcx_pkg::t_cmd cmd;
    pcx_pkg::t_sts sts;

    // controller: header/data phase and run sequencing
    pcx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: header fields, frame position, output register
    pcx_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_item_kind   (o_item_kind),
        .o_pixel_addr  (o_pixel_addr),
        .o_pixel_value (o_pixel_value),
        .o_status_code (o_status_code),
        .o_run_last    (o_run_last)
    );

    // a status word always ends the words of its input byte
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_item_kind == pcx_pkg::KIND_STATUS) |-> o_run_last)
        else $error("status word without run_last");

    // pixel words carry a clean status field and stay inside the frame
    a_pixel_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_item_kind == pcx_pkg::KIND_PIXEL) |->
        (o_status_code == pcx_pkg::ST_OK &&
         o_pixel_addr < pcx_pkg::ADDR_W'(pcx_pkg::FRAME_WIDTH * pcx_pkg::FRAME_HEIGHT)))
        else $error("pixel word fields out of range");

    // input is never taken while a run is still being expanded
    a_no_accept_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit_pixel || cmd.load_run) |-> o_in_stall)
        else $error("input accepted during run");

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for pcx_rle_image_decoder_unit
// Streams one PCX file per run: a header (valid or broken, chosen at random),
// a short table of hand-picked data words, then random well-formed run-length
// data closed by a chosen ending (clean finish, cut file, run overflow) and a
// few trailing words. Every output word is checked against a local decoder.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // decoder progress through the file
    typedef enum logic [1:0] {DEC_HEADER, DEC_DATA, DEC_VALUE, DEC_DONE} t_dec_phase;

    // how this run's file is shaped; one status word ends the decode for good,
    // so each seed exercises one way of closing the file
    typedef enum int {
        PLAN_BAD_HEADER, PLAN_SHORT_HEADER, PLAN_EMPTY, PLAN_NO_DATA,
        PLAN_COMPLETE, PLAN_CUT_PIXEL, PLAN_CUT_RUN, PLAN_OVERFLOW
    } t_file_plan;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic                       kind;
        logic [pcx_pkg::ADDR_W-1:0] addr;
        logic [7:0]                 value;
        logic [1:0]                 code;
        logic                       ends_byte;
    } t_pcx_word;

    // directed data words; typed rows carry their own expected write
    typedef struct packed {
        logic [7:0]  data;
        logic        typed;
        logic [1:0]  n_words;
        logic [15:0] addr;
        logic [7:0]  value;
    } t_table_row;

    localparam t_table_row DIRECTED_ROWS [14] = '{
        '{8'h00, 1'b1, 2'd1, 16'd0, 8'h00},                     // smallest literal pixel
        '{8'hBF, 1'b1, 2'd1, 16'd1, 8'hBF},                     // top bits 10: literal
        '{8'h7F, 1'b1, 2'd1, 16'd2, 8'h7F},                     // top bits 01: literal
        '{pcx_pkg::RUN_MARK, 1'b1, 2'd0, 16'd0, 8'h00},         // zero-length run...
        '{8'h55, 1'b1, 2'd0, 16'd0, 8'h00},                     // ...eats its value
        '{pcx_pkg::RUN_MARK | 8'd1, 1'b1, 2'd0, 16'd0, 8'h00},  // run of one
        '{8'hFF, 1'b1, 2'd1, 16'd3, 8'hFF},
        '{pcx_pkg::RUN_MARK | pcx_pkg::RUN_MASK, 1'b0, 2'd0, 16'd0, 8'h00}, // longest run
        '{8'hC3, 1'b0, 2'd0, 16'd0, 8'h00},
        '{8'h80, 1'b0, 2'd0, 16'd0, 8'h00},
        '{pcx_pkg::RUN_MARK | 8'd2, 1'b0, 2'd0, 16'd0, 8'h00},
        '{8'h00, 1'b0, 2'd0, 16'd0, 8'h00},
        '{8'h3F, 1'b0, 2'd0, 16'd0, 8'h00},
        '{8'h40, 1'b0, 2'd0, 16'd0, 8'h00}
    };

    // ---------------------------------------------------------------- DUT ports
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic [7:0]                 i_data_byte = 8'h00;
    logic                       i_last_byte = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic                       o_item_kind;
    logic [pcx_pkg::ADDR_W-1:0] o_pixel_addr;
    logic [7:0]                 o_pixel_value;
    logic [1:0]                 o_status_code;
    logic                       o_run_last;

    pcx_rle_image_decoder_unit dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------------------------------------------------- decoder model
    t_dec_phase                dec_phase = DEC_HEADER;
    logic [pcx_pkg::OFF_W-1:0] hdr_pos   = '0;
    logic                      hdr_good  = 1'b1;
    logic [15:0]               x_max     = '0;
    logic [15:0]               y_count   = '0;
    int unsigned               col_pos   = 0;
    int unsigned               row_pos   = 0;
    logic [5:0]                run_len   = '0;

    t_pcx_word byte_words[$];   // words caused by the byte just taken
    t_pcx_word due_words[$];    // words still owed by the block, oldest first

    int unsigned accepted_bytes = 0;
    int unsigned err_count = 0;

    function automatic void add_word(logic k, int unsigned a, logic [7:0] v, logic [1:0] c);
        t_pcx_word w;
        w.kind = k;
        w.addr = a[pcx_pkg::ADDR_W-1:0];
        w.value = v;
        w.code = c;
        w.ends_byte = 1'b0;
        byte_words.push_back(w);
    endfunction

    // close the file: the status word is the last thing the block ever says
    function automatic void finish_file(logic [1:0] c);
        dec_phase = DEC_DONE;
        add_word(pcx_pkg::KIND_STATUS, 0, 8'h00, c);
    endfunction

    function automatic void paint_run(int unsigned len, logic [7:0] v, logic lst);
        int unsigned k;
        // a run may reach one column past xmax, never further
        if (len + col_pos > x_max + 2) begin
            finish_file(pcx_pkg::ST_MAL);
            return;
        end
        for (k = 0; k < len; k++)
            add_word(pcx_pkg::KIND_PIXEL, row_pos * pcx_pkg::FRAME_WIDTH + col_pos + k,
                     v, pcx_pkg::ST_OK);
        col_pos += len;
        if (col_pos > x_max) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= y_count) begin
                finish_file(pcx_pkg::ST_OK);
                return;
            end
        end
        dec_phase = DEC_DATA;
        if (lst)
            finish_file(pcx_pkg::ST_MAL);
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic lst);
        t_pcx_word w;
        byte_words.delete();
        case (dec_phase)
            DEC_HEADER: begin
                case (hdr_pos)
                    pcx_pkg::OFF_MANUF:   if (b != pcx_pkg::MANUFACTURER) hdr_good = 1'b0;
                    pcx_pkg::OFF_VERSION: if (b != pcx_pkg::VERSION) hdr_good = 1'b0;
                    pcx_pkg::OFF_ENCODE:  if (b != pcx_pkg::ENCODING) hdr_good = 1'b0;
                    pcx_pkg::OFF_BPP:     if (b != pcx_pkg::BITS_PER_PIX) hdr_good = 1'b0;
                    pcx_pkg::OFF_XMAX_LO: x_max[7:0] = b;
                    pcx_pkg::OFF_XMAX_HI: x_max[15:8] = b;
                    pcx_pkg::OFF_YMAX_LO: y_count[7:0] = b;
                    pcx_pkg::OFF_YMAX_HI: y_count[15:8] = b;
                    default: ;
                endcase
                if (hdr_pos == pcx_pkg::OFF_LAST) begin
                    if (!hdr_good || x_max >= pcx_pkg::FRAME_WIDTH
                        || y_count >= pcx_pkg::FRAME_HEIGHT)
                        finish_file(pcx_pkg::ST_HDR);
                    else if (y_count == 0)
                        finish_file(pcx_pkg::ST_OK);
                    else if (lst)
                        finish_file(pcx_pkg::ST_MAL);
                    else
                        dec_phase = DEC_DATA;
                end else begin
                    hdr_pos = hdr_pos + 1'b1;
                    if (lst)
                        finish_file(pcx_pkg::ST_HDR);
                end
            end
            DEC_DATA: begin
                if ((b & pcx_pkg::RUN_MARK) == pcx_pkg::RUN_MARK) begin
                    run_len = 6'(b & pcx_pkg::RUN_MASK);
                    if (lst)
                        finish_file(pcx_pkg::ST_MAL);
                    else
                        dec_phase = DEC_VALUE;
                end else begin
                    paint_run(1, b, lst);
                end
            end
            DEC_VALUE: paint_run(run_len, b, lst);
            default: ;
        endcase
        if (byte_words.size() > 0) begin
            w = byte_words.pop_back();
            w.ends_byte = 1'b1;
            byte_words.push_back(w);
        end
    endfunction

    // ---------------------------------------------------------------- idling
    // rotate the idle mode every 48 accepted words so gaps land everywhere
    function automatic t_idle_mode idle_mode();
        return t_idle_mode'((accepted_bytes / 48) % 4);
    endfunction

    function automatic bit sender_waits();
        case (idle_mode())
            IDLE_SENDER: return $urandom_range(0, 99) < 84;
            IDLE_BOTH:   return $urandom_range(0, 99) < 30;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode())
            IDLE_RECEIVER: return $urandom_range(0, 99) < 84;
            IDLE_BOTH:     return $urandom_range(0, 99) < 30;
            default:       return 1'b0;
        endcase
    endfunction

    // -------------------------------------------------------------- input side
    // Offer one file word, hold it until taken, then advance the model.
    // A typed row replaces the model's words with the ones from the table.
    task automatic send_byte(input logic [7:0] b, input logic lst = 1'b0,
                             input logic typed = 1'b0, input int n_typed = 0,
                             input int unsigned t_addr = 0, input logic [7:0] t_val = 8'h00);
        t_pcx_word w;
        while (sender_waits()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= lst;
        do @(posedge i_clk); while (o_in_stall);
        accepted_bytes++;
        decode_byte(b, lst);
        if (typed) begin
            byte_words.delete();
            if (n_typed > 0) begin
                w = '{pcx_pkg::KIND_PIXEL, t_addr[pcx_pkg::ADDR_W-1:0], t_val,
                      pcx_pkg::ST_OK, 1'b1};
                byte_words.push_back(w);
            end
        end
        foreach (byte_words[i])
            due_words.push_back(byte_words[i]);
    endtask

    task automatic send_run(input int unsigned len, input logic [7:0] v, input logic cut);
        send_byte(pcx_pkg::RUN_MARK | 8'(len));
        send_byte(v, cut);
    endtask

    // ------------------------------------------------------------- output side
    // Check each taken word against the oldest owed one; drive the stall.
    always @(posedge i_clk) begin : out_check
        t_pcx_word seen;
        t_pcx_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen = '{o_item_kind, o_pixel_addr, o_pixel_value, o_status_code, o_run_last};
            if (due_words.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected word: kind %0d addr %0d value %02h code %0d last %0d",
                             seen.kind, seen.addr, seen.value, seen.code, seen.ends_byte);
            end else begin
                want = due_words.pop_front();
                if (seen !== want) begin
                    err_count++;
                    if (err_count <= 10)
                        $display({"word mismatch: expected kind %0d addr %0d value %02h ",
                                  "code %0d last %0d, got kind %0d addr %0d value %02h ",
                                  "code %0d last %0d"},
                                 want.kind, want.addr, want.value, want.code, want.ends_byte,
                                 seen.kind, seen.addr, seen.value, seen.code, seen.ends_byte);
                end
            end
        end
        i_out_stall <= receiver_stalls();
    end

    // --------------------------------------------------------------- stimulus
    initial begin : stimulus
        t_file_plan  plan;
        logic [7:0]  header_img [pcx_pkg::HEADER_BYTES];
        int unsigned xmax_cfg;
        int unsigned ymax_cfg;
        int unsigned cut_at;
        int unsigned k;
        int unsigned r;
        int unsigned room;
        int unsigned len;
        int unsigned sent;
        bit          deep;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // pick how this file ends; most seeds decode deep into the data
        r = $urandom_range(0, 19);
        if (r < 1)       plan = PLAN_BAD_HEADER;
        else if (r < 2)  plan = PLAN_SHORT_HEADER;
        else if (r < 3)  plan = PLAN_EMPTY;
        else if (r < 4)  plan = PLAN_NO_DATA;
        else if (r < 9)  plan = PLAN_COMPLETE;
        else if (r < 14) plan = PLAN_CUT_PIXEL;
        else if (r < 17) plan = PLAN_CUT_RUN;
        else             plan = PLAN_OVERFLOW;
        deep = plan >= PLAN_COMPLETE;

        // build the header: random filler, checked fields set right
        for (k = 0; k < pcx_pkg::HEADER_BYTES; k++)
            header_img[k] = 8'($urandom_range(0, 255));
        header_img[pcx_pkg::OFF_MANUF]   = pcx_pkg::MANUFACTURER;
        header_img[pcx_pkg::OFF_VERSION] = pcx_pkg::VERSION;
        header_img[pcx_pkg::OFF_ENCODE]  = pcx_pkg::ENCODING;
        header_img[pcx_pkg::OFF_BPP]     = pcx_pkg::BITS_PER_PIX;
        // keep xmax wide enough that the longest run fits in a row
        xmax_cfg = ($urandom_range(0, 3) == 0) ? pcx_pkg::FRAME_WIDTH - 1
                                               : $urandom_range(66, pcx_pkg::FRAME_WIDTH - 2);
        // a clean finish needs few rows; otherwise leave room for the random part
        ymax_cfg = (plan == PLAN_COMPLETE) ? $urandom_range(2, 4)
                                           : $urandom_range(100, pcx_pkg::FRAME_HEIGHT - 1);
        if (plan == PLAN_EMPTY)
            ymax_cfg = 0;
        if (plan == PLAN_BAD_HEADER) begin
            // break exactly one of the checked fields
            case ($urandom_range(0, 5))
                0: header_img[pcx_pkg::OFF_MANUF] =
                       pcx_pkg::MANUFACTURER ^ 8'($urandom_range(1, 255));
                1: header_img[pcx_pkg::OFF_VERSION] =
                       pcx_pkg::VERSION ^ 8'($urandom_range(1, 255));
                2: header_img[pcx_pkg::OFF_ENCODE] =
                       pcx_pkg::ENCODING ^ 8'($urandom_range(1, 255));
                3: header_img[pcx_pkg::OFF_BPP] =
                       pcx_pkg::BITS_PER_PIX ^ 8'($urandom_range(1, 255));
                4: xmax_cfg = $urandom_range(0, 1)
                            ? $urandom_range(16'h8000, 16'hFFFF)
                            : $urandom_range(pcx_pkg::FRAME_WIDTH, 16'h7FFF);
                default: ymax_cfg = $urandom_range(0, 1)
                                  ? $urandom_range(16'h8000, 16'hFFFF)
                                  : $urandom_range(pcx_pkg::FRAME_HEIGHT, 16'h7FFF);
            endcase
        end
        header_img[pcx_pkg::OFF_XMAX_LO] = xmax_cfg[7:0];
        header_img[pcx_pkg::OFF_XMAX_HI] = xmax_cfg[15:8];
        header_img[pcx_pkg::OFF_YMAX_LO] = ymax_cfg[7:0];
        header_img[pcx_pkg::OFF_YMAX_HI] = ymax_cfg[15:8];

        // stream the header, cut short or flagged last where the plan says
        cut_at = (plan == PLAN_SHORT_HEADER) ? $urandom_range(0, pcx_pkg::HEADER_BYTES - 2)
                                             : pcx_pkg::HEADER_BYTES - 1;
        for (k = 0; k <= cut_at; k++)
            send_byte(header_img[k],
                      (k == cut_at) && (plan == PLAN_SHORT_HEADER || plan == PLAN_NO_DATA ||
                                        (plan == PLAN_EMPTY && $urandom_range(0, 1))));

        // directed data words; after an early status they are simply dropped
        foreach (DIRECTED_ROWS[i])
            send_byte(DIRECTED_ROWS[i].data, 1'b0, DIRECTED_ROWS[i].typed && deep,
                      DIRECTED_ROWS[i].n_words, DIRECTED_ROWS[i].addr, DIRECTED_ROWS[i].value);

        // hold input until the block has paid out everything owed
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due_words.size() != 0)
            @(posedge i_clk);

        if (deep) begin
            // random well-formed data: literal pixels and runs that fit the row,
            // biased toward ending exactly at xmax or one column past it
            sent = 0;
            while (dec_phase != DEC_DONE && (plan == PLAN_COMPLETE || sent < 310)) begin
                room = x_max + 2 - col_pos;
                if ($urandom_range(0, 1)) begin
                    send_byte(8'($urandom_range(0, 191)));
                    sent++;
                end else begin
                    r = $urandom_range(0, 3);
                    if (r == 0)
                        len = room;
                    else if (r == 1)
                        len = room - 1;
                    else
                        len = $urandom_range(0, (room < 63) ? room : 63);
                    if (len > pcx_pkg::RUN_MASK)
                        len = pcx_pkg::RUN_MASK;
                    send_run(len, 8'($urandom_range(0, 255)), 1'b0);
                    sent += 2;
                end
            end

            // close the file the way the plan asks, unless the image already ended
            if (dec_phase != DEC_DONE) begin
                room = x_max + 2 - col_pos;
                case (plan)
                    PLAN_CUT_PIXEL: begin
                        if ($urandom_range(0, 1))
                            send_byte(8'($urandom_range(0, 191)), 1'b1);
                        else
                            send_run($urandom_range(0, (room < 63) ? room : 63),
                                     8'($urandom_range(0, 255)), 1'b1);
                    end
                    PLAN_CUT_RUN:
                        send_byte(pcx_pkg::RUN_MARK | 8'($urandom_range(0, 63)), 1'b1);
                    PLAN_OVERFLOW: begin
                        // advance within the row until a run can overshoot it
                        while (x_max + 2 - col_pos >= 63) begin
                            room = x_max + 2 - col_pos;
                            send_run((room - 10 < 63) ? room - 10 : 63,
                                     8'($urandom_range(0, 255)), 1'b0);
                        end
                        room = x_max + 2 - col_pos;
                        send_run($urandom_range(room + 1, 63), 8'($urandom_range(0, 255)),
                                 1'b0);
                    end
                    default: ;
                endcase
            end
        end

        // trailing words after the status must be dropped silently; pad the
        // file out to about 460 words
        cut_at = (accepted_bytes + 12 < 460) ? 460 - accepted_bytes : 12;
        for (k = 0; k < cut_at; k++)
            send_byte(8'($urandom_range(0, 255)),
                      (k == cut_at - 1) || ($urandom_range(0, 3) == 0));

        i_in_valid <= 1'b0;
        while (due_words.size() != 0)
            @(posedge i_clk);
        // leave room for any stray word from the longest run
        repeat (100) @(posedge i_clk);

        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin : watchdog
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
